[sv/iir_pkg.sv]
package iir_pkg;

  localparam int unsigned NUM_CELLS    = 8;
  localparam int unsigned MAX_B_TAPS   = 8;
  localparam int unsigned MAX_A_TAPS   = 8;
  localparam int unsigned SAMPLE_WIDTH = 16;
  localparam int unsigned COEF_WIDTH   = 16;
  localparam int unsigned FRAC_BITS    = 12;
  localparam int unsigned ACC_WIDTH    = 38;
  localparam int unsigned CFG_IDX_W    = 3;
  localparam int unsigned CFG_DATA_W   = 64;
  localparam int unsigned TAPS_W       = 4;
  localparam int unsigned STEP_W       = 4;
  localparam int unsigned SLOT_IDX_W   = 3;

  typedef logic signed [SAMPLE_WIDTH-1:0] sample_t;
  typedef logic signed [COEF_WIDTH-1:0]   coef_t;
  typedef logic [TAPS_W-1:0]              taps_t;
  typedef logic [CFG_DATA_W-1:0]          coef_reg_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_NUM_B  = 3'd0,
    REG_NUM_A  = 3'd1,
    REG_B_LOW  = 3'd2,
    REG_B_HIGH = 3'd3,
    REG_A_LOW  = 3'd4,
    REG_A_HIGH = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_MAC,
    ST_DRAIN,
    ST_FINISH
  } state_t;

  // per-cycle commands shared by every cell of the row
  typedef struct packed {
    logic load;
    logic clear;
    logic rot_x;
    logic rot_y;
    logic push_y;
  } cell_ctl_t;

  function automatic coef_t coef_at(coef_reg_t lo, coef_reg_t hi,
                                    logic [SLOT_IDX_W-1:0] k);
    coef_reg_t r;
    r = k[2] ? hi : lo;
    return coef_t'(r[k[1:0]*COEF_WIDTH +: COEF_WIDTH]);
  endfunction

  function automatic taps_t limit_taps(taps_t n, taps_t depth);
    return (n > depth) ? depth : n;
  endfunction

endpackage

[sv/iir_difference_equation_filter.sv]
// Direct form I IIR filter, 16-bit samples, Q4.12 coefficients.
// Input channel: in_valid/in_ready with in_sample_in and in_start_of_signal;
// a set start flag zeroes both histories before the sample is shifted in.
// Result channel: out_valid/out_ready with out_sample_out (rounded and
// saturated) and out_clipped. One result per item.
// Configuration: cfg_we/cfg_index/cfg_wdata, for the user to write only
// while idle; the block does not enforce it. Histories live in a row of
// eight cells that rotates past one shared multiply-accumulate unit: eight
// feedforward steps, then eight feedback.
// Items are taken one at a time: the next is accepted only after the sixteen
// passes through the single multiplier, the drain and the rounding step.
// A finished result waits in the output register; a new item is accepted
// while it waits, and the next result holds in the rounding cycle until the
// output register is free.
// Reset (synchronous, active low) restores default coefficients (unity
// gain pass-through), clears the histories and drops out_valid.
module iir_difference_equation_filter (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  iir_pkg::sample_t                    in_sample_in,
  input  logic                                in_start_of_signal,
  output logic                                out_valid,
  input  logic                                out_ready,
  output iir_pkg::sample_t                    out_sample_out,
  output logic                                out_clipped,
  input  logic                                cfg_we,
  input  logic [iir_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [iir_pkg::CFG_DATA_W-1:0]      cfg_wdata
);
  import iir_pkg::*;

  taps_t     num_b_r, num_a_r;
  coef_reg_t b_lo_r, b_hi_r, a_lo_r, a_hi_r;

  state_t               state_r, state_nxt;
  logic [STEP_W-1:0]    step_r, step_nxt;
  logic                 out_valid_r, out_valid_nxt;
  sample_t              out_sample_r;
  logic                 out_clip_r;

  cell_ctl_t ctl;
  logic      fire;
  logic      term_en;
  logic      acc_en;
  taps_t     nb_lim, na_lim;
  taps_t     step_tap;
  coef_t     coef_sel;
  sample_t   sample_sel;
  sample_t   y_new;
  logic      clip_new;

  sample_t x_q [NUM_CELLS];
  sample_t y_q [NUM_CELLS];

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_b_r <= taps_t'(1);
      num_a_r <= '0;
      b_lo_r  <= coef_reg_t'(1 << FRAC_BITS);
      b_hi_r  <= '0;
      a_lo_r  <= '0;
      a_hi_r  <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_NUM_B:  num_b_r <= cfg_wdata[TAPS_W-1:0];
        REG_NUM_A:  num_a_r <= cfg_wdata[TAPS_W-1:0];
        REG_B_LOW:  b_lo_r  <= cfg_wdata;
        REG_B_HIGH: b_hi_r  <= cfg_wdata;
        REG_A_LOW:  a_lo_r  <= cfg_wdata;
        REG_A_HIGH: a_hi_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  assign nb_lim   = limit_taps(num_b_r, taps_t'(MAX_B_TAPS));
  assign na_lim   = limit_taps(num_a_r, taps_t'(MAX_A_TAPS));
  assign step_tap = {1'b0, step_r[SLOT_IDX_W-1:0]};
  assign fire     = !out_valid_r || out_ready;

  always_comb begin
    state_nxt     = state_r;
    step_nxt      = step_r;
    out_valid_nxt = out_valid_r;
    in_ready      = 1'b0;
    ctl           = '0;
    term_en       = 1'b0;
    acc_en        = 1'b0;
    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end
    case (state_r)
      ST_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          ctl.load  = 1'b1;
          ctl.clear = in_start_of_signal;
          step_nxt  = '0;
          state_nxt = ST_MAC;
        end
      end
      ST_MAC: begin
        acc_en = 1'b1;
        if (step_r[STEP_W-1]) begin
          ctl.rot_y = 1'b1;
          term_en   = step_tap < na_lim;
        end else begin
          ctl.rot_x = 1'b1;
          term_en   = step_tap < nb_lim;
        end
        step_nxt = step_r + STEP_W'(1);
        if (step_r == '1) begin
          state_nxt = ST_DRAIN;
        end
      end
      ST_DRAIN: begin
        acc_en    = 1'b1;
        state_nxt = ST_FINISH;
      end
      ST_FINISH: begin
        if (fire) begin
          ctl.push_y    = 1'b1;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      step_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      step_r      <= step_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.push_y) begin
      out_sample_r <= y_new;
      out_clip_r   <= clip_new;
    end
  end

  // row of history cells; cell 0 is the head seen by the mac
  cell_ctl_t ctl_row;

  always_comb begin
    ctl_row = ctl;
    if (!rst_n) begin
      ctl_row       = '0;
      ctl_row.load  = 1'b1;
      ctl_row.clear = 1'b1;
    end
  end

  for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
    sample_t x_left, y_left;
    if (k == 0) begin : g_head
      assign x_left = rst_n ? in_sample_in : '0;
      assign y_left = y_new;
    end else begin : g_body
      assign x_left = (ctl_row.clear) ? '0 : x_q[k-1];
      assign y_left = y_q[k-1];
    end
    iir_cell u_cell (
      .clk     (clk),
      .ctl     (ctl_row),
      .x_left  (x_left),
      .y_left  (y_left),
      .x_right (x_q[(k + 1) % NUM_CELLS]),
      .y_right (y_q[(k + 1) % NUM_CELLS]),
      .x_q     (x_q[k]),
      .y_q     (y_q[k])
    );
  end

  assign coef_sel = step_r[STEP_W-1]
                  ? coef_at(a_lo_r, a_hi_r, step_r[SLOT_IDX_W-1:0])
                  : coef_at(b_lo_r, b_hi_r, step_r[SLOT_IDX_W-1:0]);
  assign sample_sel = step_r[STEP_W-1] ? y_q[0] : x_q[0];

  iir_mac u_mac (
    .clk     (clk),
    .clear   (ctl.load),
    .acc_en  (acc_en),
    .term_en (term_en),
    .sub     (step_r[STEP_W-1]),
    .coef    (coef_sel),
    .sample  (sample_sel),
    .y       (y_new),
    .clip    (clip_new)
  );

  assign out_valid      = out_valid_r;
  assign out_sample_out = out_sample_r;
  assign out_clipped    = out_clip_r;

endmodule

[sv/iir_cell.sv]
module iir_cell (
  input  logic               clk,
  input  iir_pkg::cell_ctl_t ctl,
  input  iir_pkg::sample_t   x_left,
  input  iir_pkg::sample_t   y_left,
  input  iir_pkg::sample_t   x_right,
  input  iir_pkg::sample_t   y_right,
  output iir_pkg::sample_t   x_q,
  output iir_pkg::sample_t   y_q
);
  import iir_pkg::*;

  sample_t x_r, x_nxt;
  sample_t y_r, y_nxt;

  always_comb begin
    x_nxt = x_r;
    y_nxt = y_r;
    if (ctl.load) begin
      x_nxt = x_left;
      if (ctl.clear) begin
        y_nxt = '0;
      end
    end else begin
      if (ctl.rot_x) begin
        x_nxt = x_right;
      end
      if (ctl.rot_y) begin
        y_nxt = y_right;
      end else if (ctl.push_y) begin
        y_nxt = y_left;
      end
    end
  end

  // histories reset through the row's load/clear commands
  always_ff @(posedge clk) begin
    x_r <= x_nxt;
    y_r <= y_nxt;
  end

  assign x_q = x_r;
  assign y_q = y_r;

endmodule

[sv/iir_mac.sv]
module iir_mac (
  input  logic             clk,
  input  logic             clear,
  input  logic             acc_en,
  input  logic             term_en,
  input  logic             sub,
  input  iir_pkg::coef_t   coef,
  input  iir_pkg::sample_t sample,
  output iir_pkg::sample_t y,
  output logic             clip
);
  import iir_pkg::*;

  localparam int unsigned PROD_W = SAMPLE_WIDTH + COEF_WIDTH;
  localparam int unsigned Q_W    = ACC_WIDTH - FRAC_BITS;
  localparam logic signed [ACC_WIDTH-1:0] ROUND =
    ACC_WIDTH'(1) <<< (FRAC_BITS - 1);
  localparam logic signed [Q_W-1:0] MAXV = Q_W'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam logic signed [Q_W-1:0] MINV = -MAXV - Q_W'(1);

  logic signed [PROD_W-1:0]    prod_r, prod_nxt;
  logic                        sub_r;
  logic signed [ACC_WIDTH-1:0] acc_r, acc_nxt;
  logic signed [ACC_WIDTH-1:0] prod_ext;
  logic signed [ACC_WIDTH-1:0] rnd;
  logic signed [Q_W-1:0]       q;

  assign prod_nxt = term_en ? PROD_W'(coef * sample) : '0;
  assign prod_ext = ACC_WIDTH'(prod_r);

  always_comb begin
    acc_nxt = acc_r;
    if (clear) begin
      acc_nxt = '0;
    end else if (acc_en) begin
      acc_nxt = sub_r ? acc_r - prod_ext : acc_r + prod_ext;
    end
  end

  always_ff @(posedge clk) begin
    prod_r <= clear ? '0 : prod_nxt;
    sub_r  <= sub;
    acc_r  <= acc_nxt;
  end

  // add half then arithmetic shift gives round half up
  assign rnd = acc_r + ROUND;
  assign q   = rnd[ACC_WIDTH-1:FRAC_BITS];

  always_comb begin
    clip = 1'b0;
    y    = sample_t'(q);
    if (q > MAXV) begin
      y    = sample_t'(MAXV);
      clip = 1'b1;
    end else if (q < MINV) begin
      y    = sample_t'(MINV);
      clip = 1'b1;
    end
  end

endmodule

[sv/iir_chk.sv]
module iir_chk (
  input logic                           clk,
  input logic                           rst_n,
  input logic                           in_valid,
  input logic                           in_ready,
  input logic                           out_valid,
  input logic                           out_ready,
  input iir_pkg::sample_t               out_sample_out,
  input logic                           out_clipped
);
  import iir_pkg::*;

  localparam sample_t SAT_MAX = sample_t'((1 << (SAMPLE_WIDTH - 1)) - 1);
  localparam sample_t SAT_MIN = ~SAT_MAX;

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_sample_out)
                                && $stable(out_clipped))
    else $error("result changed while stalled");

  a_reset_out: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("out_valid set after reset");

  // one item at a time: busy right after an accept
  a_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("item accepted while busy");

  a_clip_rail: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_clipped |-> out_sample_out == SAT_MAX
                                 || out_sample_out == SAT_MIN)
    else $error("clipped result not at a rail");

endmodule

bind iir_difference_equation_filter iir_chk u_iir_chk (.*);
